FILE: rtl/het_pkg.sv
// ---------------------------------------------------------------------------
// het_pkg
// Shared types and constants for the Hermite edge tessellator.
// ---------------------------------------------------------------------------
`default_nettype none

package het_pkg;

    localparam int COORD_W = 32;
    localparam int IDX_W   = 6;
    localparam int LVL_W   = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] start_tan_x;
        logic signed [COORD_W-1:0] start_tan_y;
        logic signed [COORD_W-1:0] end_tan_x;
        logic signed [COORD_W-1:0] end_tan_y;
        logic        [LVL_W-1:0]   subdiv_level;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic        [IDX_W-1:0]   step_index;
        logic                      last;
    } t_out_word;

    typedef struct packed {
        logic             load;
        logic             issue;
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [LVL_W-1:0] lvl;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic advance;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/hermite_edge_tessellator.sv
// ---------------------------------------------------------------------------
// hermite_edge_tessellator
// Cubic Hermite edge tessellation: 2^L-1 interior points per edge word.
// ---------------------------------------------------------------------------
// Throughput: one point per cycle from the 7-stage weight/product pipe
//   while the output is not stalled; next edge taken once the pipe has
//   emptied.
// Reset: synchronous, active low; clears sequencer state and valid bits.
`default_nettype none

module hermite_edge_tessellator #(
    parameter int MAX_LEVEL = 6,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire het_pkg::t_in_word   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output het_pkg::t_out_word       o_out_data
);

    het_pkg::t_dp_cmd cmd;
    het_pkg::t_dp_sts sts;

    het_ctrl #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_level    (i_in_data.subdiv_level),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    het_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/het_ctrl.sv
// ---------------------------------------------------------------------------
// het_ctrl
// Sequencer: takes an edge word, clamps the level and issues the step
// indices 1 .. 2^L-1 to the datapath, then waits for the pipe to empty.
// ---------------------------------------------------------------------------
`default_nettype none

module het_ctrl #(
    parameter int MAX_LEVEL = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [het_pkg::LVL_W-1:0]  i_level,
    input  wire het_pkg::t_dp_sts           i_sts,
    output het_pkg::t_dp_cmd                o_cmd
);

    localparam int IW = het_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state                    r_state;
    logic [IW-1:0]             r_idx;
    logic [IW-1:0]             r_last_idx;

    logic [het_pkg::LVL_W-1:0] lvl_c;
    logic [IW:0]               span;
    logic                      accept;

    always_comb begin
        if (i_level > het_pkg::LVL_W'(MAX_LEVEL)) begin
            lvl_c = het_pkg::LVL_W'(MAX_LEVEL);
        end else begin
            lvl_c = i_level;
        end
        span       = ((IW + 1)'(1) << lvl_c) - (IW + 1)'(1);
        o_in_ready = (r_state == S_IDLE);
        accept     = i_in_valid && o_in_ready;

        o_cmd.load  = accept;
        o_cmd.lvl   = lvl_c;
        o_cmd.issue = (r_state == S_RUN) && i_sts.advance;
        o_cmd.idx   = r_idx;
        o_cmd.last  = (r_idx == r_last_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (lvl_c != '0)) begin
                        r_state    <= S_RUN;
                        r_idx      <= IW'(1);
                        r_last_idx <= span[IW-1:0];
                    end
                end
                S_RUN: begin
                    if (o_cmd.issue) begin
                        if (o_cmd.last) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    if (!i_sts.busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_issue_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_state == S_RUN) && i_sts.advance)
        else $error("step issued outside run or under stall");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && o_cmd.last) |=> (r_state == S_DRAIN))
        else $error("final step did not lead to drain");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_idx != '0) && (r_idx <= r_last_idx))
        else $error("step index out of range");

endmodule

`default_nettype wire

FILE: rtl/het_dp.sv
// ---------------------------------------------------------------------------
// het_dp
// Datapath: operand registers and a seven-stage pipe from step index to
// Hermite weights, products and sums, then output rounding and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module het_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire het_pkg::t_in_word   i_in_data,
    input  wire het_pkg::t_dp_cmd    i_cmd,
    output het_pkg::t_dp_sts         o_sts,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output het_pkg::t_out_word       o_out_data
);

    localparam int IW    = het_pkg::IDX_W;
    localparam int LW    = het_pkg::LVL_W;
    localparam int CW    = het_pkg::COORD_W;
    localparam int I2_W  = 2 * IW;
    localparam int I3_W  = 3 * IW;
    localparam int NUM_W = 22;
    localparam int SH_W  = NUM_W + FRAC_BITS;
    localparam int WT_W  = FRAC_BITS + 2;
    localparam int CRD_W = CW + 1;
    localparam int PR_W  = WT_W + CRD_W;
    localparam int ACC_W = PR_W + 2;
    localparam int NST   = 7;
    localparam logic [4:0] FRAC_U = 5'(FRAC_BITS);
    localparam logic signed [ACC_W-1:0] RND_C = ACC_W'(1) << (FRAC_BITS - 1);

    // operands held for the whole edge
    logic        [LW-1:0]    r_lvl;
    logic        [4:0]       r_den;
    logic                    r_fix_up;
    logic        [4:0]       r_fix_sh;
    logic signed [CRD_W-1:0] r_cx [4];
    logic signed [CRD_W-1:0] r_cy [4];

    // pipe
    logic [NST-1:0]          r_vld;
    logic [IW-1:0]           r_idx_p  [NST];
    logic                    r_last_p [NST];
    logic [I2_W-1:0]         r_i2;
    logic [I2_W-1:0]         r_i2_s2;
    logic [I3_W-1:0]         r_i3;
    logic signed [NUM_W-1:0] r_num [4];
    logic signed [WT_W-1:0]  r_wt  [4];
    logic signed [PR_W-1:0]  r_px  [4];
    logic signed [PR_W-1:0]  r_py  [4];
    logic signed [ACC_W-1:0] r_sx  [2];
    logic signed [ACC_W-1:0] r_sy  [2];
    logic signed [ACC_W-1:0] r_tx;
    logic signed [ACC_W-1:0] r_ty;

    logic                    r_out_valid;
    het_pkg::t_out_word      r_out;

    logic                    advance;
    logic [4:0]              den;
    logic signed [NUM_W-1:0] i3s;
    logic signed [NUM_W-1:0] i2n;
    logic signed [NUM_W-1:0] in2;
    logic signed [NUM_W-1:0] n3;
    logic signed [NUM_W-1:0] num [4];
    logic signed [WT_W-1:0]  wt  [4];

    function automatic logic signed [CW-1:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = (v + RND_C) >>> FRAC_BITS;
        if ((&r[ACC_W-1:CW-1]) || !(|r[ACC_W-1:CW-1])) begin
            return r[CW-1:0];
        end else if (r[ACC_W-1]) begin
            return {1'b1, {(CW - 1){1'b0}}};
        end else begin
            return {1'b0, {(CW - 1){1'b1}}};
        end
    endfunction

    assign advance       = !r_out_valid || i_out_ready;
    assign o_sts.advance = advance;
    assign o_sts.busy    = |r_vld;
    assign o_out_valid   = r_out_valid;
    assign o_out_data    = r_out;
    assign den           = {2'b00, i_cmd.lvl} + {1'b0, i_cmd.lvl, 1'b0};

    // weight numerators over 2^(3L)
    always_comb begin
        i3s = NUM_W'(r_i3);
        i2n = NUM_W'(r_i2_s2) << r_lvl;
        in2 = NUM_W'(r_idx_p[1]) << {r_lvl, 1'b0};
        n3  = NUM_W'(1) << r_den;
        num[0] = (i3s <<< 1) - (i2n <<< 1) - i2n + n3;
        num[1] = (i2n <<< 1) + i2n - (i3s <<< 1);
        num[2] = i3s - (i2n <<< 1) + in2;
        num[3] = i3s - i2n;
    end

    // scale to FRAC_BITS: exact left shift, or round half up
    always_comb begin
        logic signed [SH_W-1:0] wide;
        logic signed [SH_W-1:0] rnd;
        rnd = SH_W'(1) << (r_fix_sh - 5'd1);
        for (int k = 0; k < 4; k++) begin
            wide = SH_W'(r_num[k]);
            if (r_fix_up) begin
                wt[k] = WT_W'(wide <<< r_fix_sh);
            end else begin
                wt[k] = WT_W'((wide + rnd) >>> r_fix_sh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_vld       <= {r_vld[NST-2:0], i_cmd.issue};
            r_out_valid <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lvl    <= i_cmd.lvl;
            r_den    <= den;
            r_fix_up <= (den <= FRAC_U);
            r_fix_sh <= (den <= FRAC_U) ? (FRAC_U - den) : (den - FRAC_U);
            r_cx[0]  <= CRD_W'(i_in_data.start_x);
            r_cy[0]  <= CRD_W'(i_in_data.start_y);
            r_cx[1]  <= CRD_W'(i_in_data.end_x);
            r_cy[1]  <= CRD_W'(i_in_data.end_y);
            r_cx[2]  <= CRD_W'(i_in_data.start_tan_x);
            r_cy[2]  <= CRD_W'(i_in_data.start_tan_y);
            r_cx[3]  <= -CRD_W'(i_in_data.end_tan_x);
            r_cy[3]  <= -CRD_W'(i_in_data.end_tan_y);
        end
        if (advance) begin
            r_idx_p[0]  <= i_cmd.idx;
            r_last_p[0] <= i_cmd.last;
            for (int s = 1; s < NST; s++) begin
                r_idx_p[s]  <= r_idx_p[s-1];
                r_last_p[s] <= r_last_p[s-1];
            end
            r_i2    <= I2_W'(i_cmd.idx) * I2_W'(i_cmd.idx);
            r_i2_s2 <= r_i2;
            r_i3    <= I3_W'(r_i2) * I3_W'(r_idx_p[0]);
            for (int k = 0; k < 4; k++) begin
                r_num[k] <= num[k];
                r_wt[k]  <= wt[k];
                r_px[k]  <= PR_W'(r_wt[k]) * PR_W'(r_cx[k]);
                r_py[k]  <= PR_W'(r_wt[k]) * PR_W'(r_cy[k]);
            end
            r_sx[0] <= ACC_W'(r_px[0]) + ACC_W'(r_px[1]);
            r_sx[1] <= ACC_W'(r_px[2]) + ACC_W'(r_px[3]);
            r_sy[0] <= ACC_W'(r_py[0]) + ACC_W'(r_py[1]);
            r_sy[1] <= ACC_W'(r_py[2]) + ACC_W'(r_py[3]);
            r_tx    <= r_sx[0] + r_sx[1];
            r_ty    <= r_sy[0] + r_sy[1];
            r_out.point_x    <= round_sat(r_tx);
            r_out.point_y    <= round_sat(r_ty);
            r_out.step_index <= r_idx_p[NST-1];
            r_out.last       <= r_last_p[NST-1];
        end
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_vld == '0))
        else $error("operands reloaded while pipe busy");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_vld == $past(r_vld)))
        else $error("pipe moved under output stall");

    a_tail_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && advance) |=> r_out_valid)
        else $error("point lost at output register");

endmodule

`default_nettype wire
